FILE: hw/rtl/psl_pkg.sv
// shared types and constants for the positional sequence list
package psl_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int POS_W     = 11;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 11;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_SORT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   read_value;
        logic        [CNT_W-1:0]   count_now;
    } t_result;

endpackage

FILE: hw/rtl/positional_sequence_list.sv
// positional sequence list: ordered list of signed words with insert, delete, get and sort
//
// input channel: i_valid / o_stall carry one transaction (operation, position, value);
//   a transaction is taken at a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry one result (status, read value, count)
//   for every input transaction, in order
// one transaction is worked on at a time; o_stall is high from the acceptance edge
//   until the result has moved into the output register
// work from acceptance to o_valid, with a free output register:
//   get: one store read; any error, or a sort of fewer than two entries: no store work
//   insert at p with count c: c + 1 - p entries shifted up, then the new value written
//   delete at p with count c: c - p entries shifted down
//   sort of n entries: a load, hold, compare and put step per key, plus one compare
//   per entry moved
// the store has one write port and one read port, one entry moves per cycle,
//   and that sets the shift and sort times
// reset (synchronous, active low) empties the list; store contents are not cleared
// while i_stall holds the output register, the next transaction can still be
//   taken and worked on; it waits in its last step until the register frees up
module positional_sequence_list #(
    parameter int DEPTH = psl_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_operation,
    input  logic [psl_pkg::POS_W-1:0]         i_position,
    input  logic signed [psl_pkg::VAL_W-1:0]  i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic signed [psl_pkg::VAL_W-1:0]  o_read_value,
    output logic [psl_pkg::CNT_W-1:0]         o_count_now
);

    // handover between sequencer and output register
    logic             push;
    logic             free;
    psl_pkg::t_result eng_res;
    psl_pkg::t_result out_res;

    // sequencer with the list store
    psl_engine #(
        .DEPTH(DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_operation(i_operation),
        .i_position (i_position),
        .i_value    (i_value),
        .i_free     (free),
        .o_push     (push),
        .o_res      (eng_res)
    );

    // output register decouples the receiver's stall from the sequencer
    psl_outbuf u_outbuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_res  (eng_res),
        .i_stall(i_stall),
        .o_free (free),
        .o_valid(o_valid),
        .o_res  (out_res)
    );

    assign o_status     = out_res.status;
    assign o_read_value = out_res.read_value;
    assign o_count_now  = out_res.count_now;

endmodule

FILE: hw/rtl/psl_engine.sv
// list store and operation sequencer: shifts, reads and insertion sort
module psl_engine #(
    parameter int DEPTH = psl_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_operation,
    input  logic [psl_pkg::POS_W-1:0]         i_position,
    input  logic signed [psl_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_free,
    output logic                              o_push,
    output psl_pkg::t_result                  o_res
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > psl_pkg::POS_W) ? CW : psl_pkg::POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GET,
        S_MOVE,
        S_INS_PUT,
        S_LOAD,
        S_HELD,
        S_CMP,
        S_PUT,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    r_left;
    logic                             r_pend;
    logic                             r_up;
    logic [AW-1:0]                    r_src;
    logic [AW-1:0]                    r_dst;
    logic [AW-1:0]                    r_tgt;
    logic [AW-1:0]                    r_k;
    logic [AW-1:0]                    r_m;
    logic signed [psl_pkg::VAL_W-1:0] r_val;
    logic signed [psl_pkg::VAL_W-1:0] r_held;
    logic signed [psl_pkg::VAL_W-1:0] r_rdval;
    psl_pkg::t_status                 r_status;

    logic signed [psl_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic signed [psl_pkg::VAL_W-1:0] r_rdata;

    logic [AW-1:0]                    rd_addr;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic signed [psl_pkg::VAL_W-1:0] wr_data;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            ins_ok;
    logic            acc_ok;
    logic            full;
    logic [AW-1:0]   tgt;
    logic            lower;

    // position checks against the current count
    assign pos_ext = CMPW'(i_position);
    assign cnt_ext = CMPW'(r_count);
    assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1));
    assign acc_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign full    = (r_count == CW'(DEPTH));
    assign tgt     = AW'(pos_ext - CMPW'(1));
    assign lower   = (r_held < r_rdata);

    assign o_stall = (r_state != S_IDLE);
    assign o_push  = (r_state == S_DONE) && i_free;

    assign o_res.status     = r_status;
    assign o_res.read_value = r_rdval;
    assign o_res.count_now  = psl_pkg::CNT_W'(r_count);

    // memory port control
    always_comb begin
        rd_addr = r_tgt;
        wr_en   = 1'b0;
        wr_addr = r_dst;
        wr_data = r_rdata;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = tgt;
            end
            S_MOVE: begin
                rd_addr = r_src;
                wr_en   = r_pend;
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_tgt;
                wr_data = r_val;
            end
            S_LOAD: begin
                rd_addr = r_k;
            end
            S_HELD: begin
                rd_addr = r_k - AW'(1);
            end
            S_CMP: begin
                rd_addr = r_m - AW'(2);
                wr_en   = lower;
                wr_addr = r_m;
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_m;
                wr_data = r_held;
            end
            default: begin
                rd_addr = r_tgt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tgt    <= tgt;
                        r_val    <= i_value;
                        r_rdval  <= '0;
                        r_status <= psl_pkg::ST_OK;
                        r_pend   <= 1'b0;
                        unique case (psl_pkg::t_op'(i_operation))
                            psl_pkg::OP_INSERT: begin
                                if (!ins_ok) begin
                                    r_status <= psl_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if (full) begin
                                    r_status <= psl_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_left  <= CW'(cnt_ext + CMPW'(1) - pos_ext);
                                    r_src   <= AW'(cnt_ext - CMPW'(1));
                                    r_up    <= 1'b1;
                                    r_state <= S_MOVE;
                                end
                            end
                            psl_pkg::OP_DELETE: begin
                                if (!acc_ok) begin
                                    r_status <= psl_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_left  <= CW'(cnt_ext - pos_ext);
                                    r_src   <= AW'(pos_ext);
                                    r_up    <= 1'b0;
                                    r_state <= S_MOVE;
                                end
                            end
                            psl_pkg::OP_GET: begin
                                if (!acc_ok) begin
                                    r_status <= psl_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_GET;
                                end
                            end
                            psl_pkg::OP_SORT: begin
                                r_k <= AW'(1);
                                if (r_count < CW'(2)) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_LOAD;
                                end
                            end
                        endcase
                    end
                end
                S_GET: begin
                    r_rdval <= r_rdata;
                    r_state <= S_DONE;
                end
                S_MOVE: begin
                    if (r_left != '0) begin
                        r_src  <= r_up ? r_src - AW'(1) : r_src + AW'(1);
                        r_dst  <= r_up ? r_src + AW'(1) : r_src - AW'(1);
                        r_left <= r_left - CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            if (r_up) begin
                                r_state <= S_INS_PUT;
                            end else begin
                                r_count <= r_count - CW'(1);
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_INS_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_LOAD: begin
                    r_state <= S_HELD;
                end
                S_HELD: begin
                    r_held  <= r_rdata;
                    r_m     <= r_k;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (lower) begin
                        if (r_m == AW'(1)) begin
                            r_m     <= '0;
                            r_state <= S_PUT;
                        end else begin
                            r_m <= r_m - AW'(1);
                        end
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if ((CW'(r_k) + CW'(1)) < r_count) begin
                        r_k     <= r_k + AW'(1);
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/psl_outbuf.sv
// result register between the sequencer and the output channel
module psl_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  psl_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output psl_pkg::t_result o_res
);

    logic             r_valid;
    psl_pkg::t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: hw/rtl/psl_checker.sv
// port-level checks for the positional sequence list, bound to the top level
module psl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_stall,
    input logic                              i_out_valid,
    input logic                              i_out_stall,
    input logic [1:0]                        i_status,
    input logic signed [psl_pkg::VAL_W-1:0]  i_read_value,
    input logic [psl_pkg::CNT_W-1:0]         i_count_now
);

    // reset leaves nothing to deliver and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("result or input stall present after reset");

    // one transaction at a time: acceptance closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input still open after a transaction was taken");

    // only a successful get returns data
    a_read_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_value != '0) |-> i_status == psl_pkg::ST_OK)
        else $error("read value on an error result");

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_status)
            && $stable(i_read_value) && $stable(i_count_now))
        else $error("stalled result changed");

endmodule

bind positional_sequence_list psl_checker u_psl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_status    (o_status),
    .i_read_value(o_read_value),
    .i_count_now (o_count_now)
);

FILE: dv/tb_positional_sequence_list.sv
// testbench for the positional sequence list: directed and random runs with a scoreboard
`timescale 1ns / 1ps

module tb_positional_sequence_list;

    localparam int LIST_DEPTH   = psl_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 525;
    localparam int SMALL_CAP    = 48;
    // worst case is every transaction shifting or sorting at full cost, taken several times over
    localparam int CYCLE_LIMIT  = 6000000;
    localparam int DRAIN_CYCLES = 64;

    localparam logic signed [psl_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(psl_pkg::VAL_W-1){1'b0}}};
    localparam logic signed [psl_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(psl_pkg::VAL_W-1){1'b1}}};

    // shadow copy of the list; works out the reply each accepted transaction should give
    class list_tracker;
        logic signed [psl_pkg::VAL_W-1:0] shadow_entries [LIST_DEPTH];
        int                               shadow_count;
        psl_pkg::t_result                 pending_replies [$];
        int                               mismatch_count;

        function new();
            shadow_count   = 0;
            mismatch_count = 0;
        endfunction

        function void note_request(psl_pkg::t_op op, logic [psl_pkg::POS_W-1:0] pos,
                                   logic signed [psl_pkg::VAL_W-1:0] val);
            psl_pkg::t_result                 reply;
            int                               p;
            int                               k;
            int                               m;
            logic signed [psl_pkg::VAL_W-1:0] held;
            reply.status     = psl_pkg::ST_OK;
            reply.read_value = '0;
            p = int'(pos);
            case (op)
                psl_pkg::OP_INSERT: begin
                    // range check wins over the full check
                    if (p < 1 || p > shadow_count + 1) begin
                        reply.status = psl_pkg::ST_RANGE;
                    end else if (shadow_count >= LIST_DEPTH) begin
                        reply.status = psl_pkg::ST_FULL;
                    end else begin
                        for (k = shadow_count; k >= p; k--)
                            shadow_entries[k] = shadow_entries[k-1];
                        shadow_entries[p-1] = val;
                        shadow_count++;
                    end
                end
                psl_pkg::OP_DELETE: begin
                    if (p < 1 || p > shadow_count) begin
                        reply.status = psl_pkg::ST_RANGE;
                    end else begin
                        for (k = p; k < shadow_count; k++)
                            shadow_entries[k-1] = shadow_entries[k];
                        shadow_count--;
                    end
                end
                psl_pkg::OP_GET: begin
                    if (p < 1 || p > shadow_count)
                        reply.status = psl_pkg::ST_RANGE;
                    else
                        reply.read_value = shadow_entries[p-1];
                end
                default: begin
                    // insertion sort, signed order
                    for (k = 1; k < shadow_count; k++) begin
                        held = shadow_entries[k];
                        m    = k;
                        while (m > 0 && held < shadow_entries[m-1]) begin
                            shadow_entries[m] = shadow_entries[m-1];
                            m--;
                        end
                        shadow_entries[m] = held;
                    end
                end
            endcase
            reply.count_now = shadow_count[psl_pkg::CNT_W-1:0];
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic [1:0] status,
                                  logic signed [psl_pkg::VAL_W-1:0] read_value,
                                  logic [psl_pkg::CNT_W-1:0] count_now);
            psl_pkg::t_result want;
            if (pending_replies.size() == 0) begin
                $error("result with no transaction waiting: status %0d value %0d count %0d",
                       status, read_value, count_now);
                mismatch_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                mismatch_count++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, read_value);
                mismatch_count++;
            end
            if (count_now !== want.count_now) begin
                $error("count_now: expected %0d, got %0d", want.count_now, count_now);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_stall;
    logic [1:0]                       i_operation;
    logic [psl_pkg::POS_W-1:0]        i_position;
    logic signed [psl_pkg::VAL_W-1:0] i_value;
    logic                             o_valid;
    logic                             i_stall;
    logic [1:0]                       o_status;
    logic signed [psl_pkg::VAL_W-1:0] o_read_value;
    logic [psl_pkg::CNT_W-1:0]        o_count_now;

    list_tracker tracker;
    int          items_sent  = 0;
    int          cycle_count = 0;
    // when set, that side runs flat out for a stretch
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;

    positional_sequence_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_read_value(o_read_value),
        .o_count_now (o_count_now)
    );

    always #10 i_clk = ~i_clk;

    // hang guard
    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("[positional_sequence_list] ERROR");
        $finish;
    end

    // present one transaction after a random gap and hold it until taken
    task automatic send_request(input psl_pkg::t_op op, input int pos,
                                input logic signed [psl_pkg::VAL_W-1:0] val);
        int gap;
        // now and then switch idling on or off on each side
        if (items_sent % 40 == 0) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_position  <= pos[psl_pkg::POS_W-1:0];
        i_value     <= val;
        // stall is looked at mid-cycle, so it is the value seen by the next edge
        do @(negedge i_clk); while (o_stall !== 1'b0);
        @(posedge i_clk);
        tracker.note_request(op, pos[psl_pkg::POS_W-1:0], val);
        items_sent++;
    endtask

    // mix of extremes, duplicates of held entries and plain random words
    function automatic logic signed [psl_pkg::VAL_W-1:0] pick_value();
        logic signed [psl_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = '0;
            3: v = '1;
            4: begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            5: begin
                if (tracker.shadow_count > 0)
                    v = tracker.shadow_entries[$urandom_range(0, tracker.shadow_count - 1)];
                else
                    v = $urandom();
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // output side: random stall before each result, then compare
    initial begin : reply_sink
        int                               wait_cycles;
        bit                               take;
        logic [1:0]                       got_status;
        logic signed [psl_pkg::VAL_W-1:0] got_value;
        logic [psl_pkg::CNT_W-1:0]        got_count;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            wait_cycles = rx_quiet ? 0 : $urandom_range(0, 6);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            take = 1'b0;
            while (!take) begin
                @(negedge i_clk);
                take       = (o_valid === 1'b1);
                got_status = o_status;
                got_value  = o_read_value;
                got_count  = o_count_now;
                @(posedge i_clk);
            end
            tracker.check_reply(got_status, got_value, got_count);
        end
    end

    initial begin : stimulus
        int           random_end;
        int           roll;
        int           limit;
        int           pos;
        int           n;
        psl_pkg::t_op op;

        tracker     = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= psl_pkg::OP_INSERT;
        i_position  <= '0;
        i_value     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // empty list: every position is out of range, sort does nothing
        send_request(psl_pkg::OP_GET,    1, $urandom());
        send_request(psl_pkg::OP_DELETE, 1, $urandom());
        send_request(psl_pkg::OP_SORT,   0, $urandom());
        // position zero and one past count+1 on insert
        send_request(psl_pkg::OP_INSERT, 0, VAL_MAX);
        send_request(psl_pkg::OP_INSERT, 2, VAL_MAX);
        send_request(psl_pkg::OP_INSERT, 1, VAL_MAX);
        // sort of a one-entry list
        send_request(psl_pkg::OP_SORT,   2047, $urandom());
        // front insert, append, middle insert: list becomes min, 0, max, -1
        send_request(psl_pkg::OP_INSERT, 1, VAL_MIN);
        send_request(psl_pkg::OP_INSERT, 3, '1);
        send_request(psl_pkg::OP_INSERT, 2, '0);
        send_request(psl_pkg::OP_GET,    0, $urandom());
        send_request(psl_pkg::OP_GET,    2047, $urandom());
        send_request(psl_pkg::OP_GET,    1, $urandom());
        send_request(psl_pkg::OP_GET,    2, $urandom());
        send_request(psl_pkg::OP_GET,    3, $urandom());
        send_request(psl_pkg::OP_GET,    4, $urandom());
        send_request(psl_pkg::OP_GET,    5, $urandom());
        send_request(psl_pkg::OP_DELETE, 0, $urandom());
        send_request(psl_pkg::OP_DELETE, 2047, $urandom());
        // signed sort: min, -1, 0, max
        send_request(psl_pkg::OP_SORT,   1, $urandom());
        send_request(psl_pkg::OP_GET,    2, $urandom());
        send_request(psl_pkg::OP_GET,    4, $urandom());
        // delete at the front, at the end, and one past the end
        send_request(psl_pkg::OP_DELETE, 1, $urandom());
        send_request(psl_pkg::OP_DELETE, 3, $urandom());
        send_request(psl_pkg::OP_DELETE, 3, $urandom());

        // ---- random part, list kept short so sorts stay cheap ----
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            roll = $urandom_range(0, 99);
            if (roll < 8 && tracker.shadow_count < SMALL_CAP) begin
                // merge: a run of appends followed by one sort
                n = $urandom_range(2, 8);
                repeat (n)
                    send_request(psl_pkg::OP_INSERT, tracker.shadow_count + 1, pick_value());
                send_request(psl_pkg::OP_SORT, $urandom_range(0, 2047), $urandom());
            end else begin
                roll = $urandom_range(0, 99);
                if (tracker.shadow_count >= SMALL_CAP) begin
                    if (roll < 60)
                        op = psl_pkg::OP_DELETE;
                    else if (roll < 85)
                        op = psl_pkg::OP_GET;
                    else
                        op = psl_pkg::OP_SORT;
                end else if (roll < 38) begin
                    op = psl_pkg::OP_INSERT;
                end else if (roll < 66) begin
                    op = psl_pkg::OP_DELETE;
                end else if (roll < 90) begin
                    op = psl_pkg::OP_GET;
                end else begin
                    op = psl_pkg::OP_SORT;
                end
                limit = (op == psl_pkg::OP_INSERT) ? tracker.shadow_count + 1
                                                   : tracker.shadow_count;
                // mostly legal positions, the rest edge and noise positions
                if (limit > 0 && $urandom_range(0, 4) != 0) begin
                    pos = $urandom_range(1, limit);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       pos = 0;
                        1:       pos = limit + 1;
                        2:       pos = 2047;
                        default: pos = $urandom_range(0, 2047);
                    endcase
                end
                send_request(op, pos, (op == psl_pkg::OP_INSERT) ? pick_value() : $urandom());
            end
        end

        send_request(psl_pkg::OP_GET, 1, $urandom());

        i_valid <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge i_clk);
        // catch any stray result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.pending_replies.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_replies.size());
            tracker.mismatch_count++;
        end
        if (tracker.mismatch_count == 0)
            $display("[positional_sequence_list] OK");
        else
            $display("[positional_sequence_list] ERROR");
        $finish;
    end

endmodule
